// File: hdl/fgn_pkg.sv
// Shared constants and elaboration-time helpers for the fractal gradient noise block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.

package fgn_pkg;

  localparam int MAX_OCTAVES_DEF      = 8;
  localparam int ANGLE_INDEX_BITS_DEF = 10;
  localparam int COORD_FRAC_BITS_DEF  = 16;

  // Register indexes on the configuration port (word address bits [3:2]).
  localparam logic [1:0] REG_SEED  = 2'd0;
  localparam logic [1:0] REG_FREQ  = 2'd1;
  localparam logic [1:0] REG_OCT   = 2'd2;

  localparam logic [31:0] SEED_RST = 32'd0;
  localparam logic [23:0] FREQ_RST = 24'd65536;
  localparam logic [3:0]  OCT_RST  = 4'd4;

  localparam logic [31:0] HASH_MUL_A = 32'd747796405;
  localparam logic [31:0] HASH_ADD_A = 32'd2891336453;
  localparam logic [31:0] HASH_MUL_B = 32'd277803737;

  localparam int PROD_W   = 57;  // signed 32-bit position times 24-bit frequency
  localparam int DOT_W    = 20;  // corner dot product in Q16
  localparam int N_W      = 21;  // lerped octave value in Q16
  localparam int LANE_LAT = 10;  // register stages inside one octave lane

  // Quarter-wave sine in Q14, evaluated only with constant arguments.
  function automatic logic [14:0] quarter_sine(input int m, input int aib);
    logic [63:0] x;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] q;
    x = 64'(m) << (30 - (aib - 2));
    theta = (x * 64'd1686629713) >> 30;
    t2 = (theta * theta) >> 30;
    acc = 64'd1 << 30;
    acc = (64'd1 << 30) - (((t2 * acc) >> 30) / 64'd210);
    acc = (64'd1 << 30) - (((t2 * acc) >> 30) / 64'd156);
    acc = (64'd1 << 30) - (((t2 * acc) >> 30) / 64'd110);
    acc = (64'd1 << 30) - (((t2 * acc) >> 30) / 64'd72);
    acc = (64'd1 << 30) - (((t2 * acc) >> 30) / 64'd42);
    acc = (64'd1 << 30) - (((t2 * acc) >> 30) / 64'd20);
    acc = (64'd1 << 30) - (((t2 * acc) >> 30) / 64'd6);
    s = (theta * acc) >> 30;
    q = (s + 64'd32768) >> 16;
    if (q > 64'd16384) begin
      q = 64'd16384;
    end
    return q[14:0];
  endfunction

endpackage

// File: hdl/fgn_hash.sv
// Two-stage multiplicative core of the corner hash: state step and first output mix.
// The final xor-shift is left to the consumer. Uses fgn_pkg hash constants.

module fgn_hash (
  input  logic        clk,
  input  logic [31:0] v_i,
  output logic [31:0] w_o
);

  logic [31:0] st_r;
  logic [31:0] w_r;
  logic [4:0]  sh;
  logic [31:0] w_nxt;

  assign sh    = {1'b0, st_r[31:28]} + 5'd4;
  assign w_nxt = ((st_r >> sh) ^ st_r) * fgn_pkg::HASH_MUL_B;

  always_ff @(posedge clk) begin
    st_r <= v_i * fgn_pkg::HASH_MUL_A + fgn_pkg::HASH_ADD_A;
    w_r  <= w_nxt;
  end

  assign w_o = w_r;

endmodule

// File: hdl/fgn_octave.sv
// One octave lane: lattice split, corner hashes, gradient lookup, dots, fade and lerp.
// Pure datapath of ten register stages; depends on fgn_pkg and fgn_hash.

module fgn_octave #(
  parameter int OCT = 0,
  parameter int AIB = fgn_pkg::ANGLE_INDEX_BITS_DEF,
  parameter int F   = fgn_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [31:0]                       seed,
  input  logic signed [fgn_pkg::PROD_W-1:0] prod_x,
  input  logic signed [fgn_pkg::PROD_W-1:0] prod_y,
  output logic signed [fgn_pkg::N_W-1:0]    n_o
);

  localparam int QTR   = 1 << (AIB - 2);
  localparam int DOT_W = fgn_pkg::DOT_W;
  localparam int N_W   = fgn_pkg::N_W;

  // Gradient table: quarter sine wave with both end points.
  logic [14:0] sin_tab [QTR+1];
  for (genvar m = 0; m <= QTR; m++) begin : g_tab
    assign sin_tab[m] = fgn_pkg::quarter_sine(m, AIB);
  end

  function automatic logic signed [15:0] sine_of(input logic [AIB-1:0] i);
    logic [AIB-3:0] r;
    logic [AIB-2:0] m;
    logic [15:0]    v;
    r = i[AIB-3:0];
    m = i[AIB-2] ? ((AIB-1)'(QTR) - {1'b0, r}) : {1'b0, r};
    v = {1'b0, sin_tab[m]};
    return i[AIB-1] ? -$signed(v) : $signed(v);
  endfunction

  // Stage 1: scale by 2^OCT and split into lattice cell and fraction.
  logic [63:0] sx_w;
  logic [63:0] sy_w;
  assign sx_w = 64'(prod_x) << OCT;
  assign sy_w = 64'(prod_y) << OCT;

  logic [31:0]  x0_r;
  logic [31:0]  y0_r [3];    // stages 1..3
  logic [F-1:0] fx_r [7];    // stages 1..7
  logic [F-1:0] fy_r [7];

  always_ff @(posedge clk) begin
    x0_r    <= sx_w[F+31:F];
    y0_r[0] <= sy_w[F+31:F];
    fx_r[0] <= sx_w[F-1:0];
    fy_r[0] <= sy_w[F-1:0];
    for (int k = 1; k < 3; k++) begin
      y0_r[k] <= y0_r[k-1];
    end
    for (int k = 1; k < 7; k++) begin
      fx_r[k] <= fx_r[k-1];
      fy_r[k] <= fy_r[k-1];
    end
  end

  // Stages 2-3: outer hash of the two cell columns.
  logic [31:0] wx0;
  logic [31:0] wx1;
  fgn_hash u_hx0 (.clk(clk), .v_i(x0_r),         .w_o(wx0));
  fgn_hash u_hx1 (.clk(clk), .v_i(x0_r + 32'd1), .w_o(wx1));

  // Fade for both axes: stages 2 (t2), 3 (t3, inner), 4 (fade).
  logic [2*F-1:0] sqx;
  logic [2*F-1:0] sqy;
  logic [F-1:0]   t2x_r;
  logic [F-1:0]   t2y_r;
  logic [2*F-1:0] cbx;
  logic [2*F-1:0] cby;
  logic [F-1:0]   t3x_r;
  logic [F-1:0]   t3y_r;
  logic [F+3:0]   inx_r;
  logic [F+3:0]   iny_r;
  logic [F+5:0]   inx_c;
  logic [F+5:0]   iny_c;
  logic [2*F+3:0] fdx;
  logic [2*F+3:0] fdy;
  logic [F:0]     fadex_r [5];  // stages 4..8
  logic [F:0]     fadey_r [6];  // stages 4..9

  assign sqx   = fx_r[0] * fx_r[0];
  assign sqy   = fy_r[0] * fy_r[0];
  assign cbx   = t2x_r * fx_r[1];
  assign cby   = t2y_r * fy_r[1];
  assign inx_c = (F+6)'(6) * {6'd0, t2x_r} + ((F+6)'(10) << F)
                 - (F+6)'(15) * {6'd0, fx_r[1]};
  assign iny_c = (F+6)'(6) * {6'd0, t2y_r} + ((F+6)'(10) << F)
                 - (F+6)'(15) * {6'd0, fy_r[1]};
  assign fdx   = t3x_r * inx_r;
  assign fdy   = t3y_r * iny_r;

  always_ff @(posedge clk) begin
    t2x_r      <= sqx[2*F-1:F];
    t2y_r      <= sqy[2*F-1:F];
    t3x_r      <= cbx[2*F-1:F];
    t3y_r      <= cby[2*F-1:F];
    inx_r      <= inx_c[F+3:0];
    iny_r      <= iny_c[F+3:0];
    fadex_r[0] <= fdx[2*F:F];
    fadey_r[0] <= fdy[2*F:F];
    for (int k = 1; k < 5; k++) begin
      fadex_r[k] <= fadex_r[k-1];
    end
    for (int k = 1; k < 6; k++) begin
      fadey_r[k] <= fadey_r[k-1];
    end
  end

  // Stage 4: finish column hashes and add row and seed for the four corners.
  // Corner order: 00, 10, 01, 11 (x offset in bit 0, y offset in bit 1).
  logic [31:0] hx0;
  logic [31:0] hx1;
  logic [31:0] y1;
  logic [31:0] v_r [4];
  assign hx0 = wx0 ^ (wx0 >> 22);
  assign hx1 = wx1 ^ (wx1 >> 22);
  assign y1  = y0_r[2] + 32'd1;

  always_ff @(posedge clk) begin
    v_r[0] <= hx0 + y0_r[2] + seed;
    v_r[1] <= hx1 + y0_r[2] + seed;
    v_r[2] <= hx0 + y1 + seed;
    v_r[3] <= hx1 + y1 + seed;
  end

  // Stages 5-6: inner hash per corner; stage 7: gradient lookup.
  logic [31:0]        wc [4];
  logic [31:0]        hc [4];
  logic [AIB-1:0]     ic [4];
  logic signed [15:0] gx_r [4];
  logic signed [15:0] gy_r [4];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    fgn_hash u_hc (.clk(clk), .v_i(v_r[c]), .w_o(wc[c]));
    assign hc[c] = wc[c] ^ (wc[c] >> 22);
    assign ic[c] = hc[c][31 -: AIB];
    always_ff @(posedge clk) begin
      gx_r[c] <= sine_of(ic[c] + AIB'(QTR));
      gy_r[c] <= sine_of(ic[c]);
    end
  end

  // Stage 8: corner dot products, floor-shifted to Q16.
  logic signed [F:0]     dx0;
  logic signed [F:0]     dx1;
  logic signed [F:0]     dy0;
  logic signed [F:0]     dy1;
  logic signed [F+17:0]  dsum [4];
  logic signed [DOT_W-1:0] dot_r [4];

  assign dx0 = $signed({1'b0, fx_r[6]});
  assign dx1 = $signed({1'b1, fx_r[6]});
  assign dy0 = $signed({1'b0, fy_r[6]});
  assign dy1 = $signed({1'b1, fy_r[6]});

  assign dsum[0] = dx0 * gx_r[0] + dy0 * gy_r[0];
  assign dsum[1] = dx1 * gx_r[1] + dy0 * gy_r[1];
  assign dsum[2] = dx0 * gx_r[2] + dy1 * gy_r[2];
  assign dsum[3] = dx1 * gx_r[3] + dy1 * gy_r[3];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      dot_r[c] <= DOT_W'(dsum[c] >>> (F - 2));
    end
  end

  // Stages 9-10: bilinear blend along x, then along y.
  function automatic logic signed [N_W-1:0] lerp(input logic signed [N_W-1:0] a,
                                                 input logic signed [N_W-1:0] b,
                                                 input logic [F:0] f);
    logic signed [N_W+F+1:0] p;
    p = (b - a) * $signed({1'b0, f});
    return a + N_W'(p >>> F);
  endfunction

  logic signed [N_W-1:0] lx0_r;
  logic signed [N_W-1:0] lx1_r;
  logic signed [N_W-1:0] n_r;

  always_ff @(posedge clk) begin
    lx0_r <= lerp(N_W'(dot_r[0]), N_W'(dot_r[1]), fadex_r[4]);
    lx1_r <= lerp(N_W'(dot_r[2]), N_W'(dot_r[3]), fadex_r[4]);
    n_r   <= lerp(lx0_r, lx1_r, fadey_r[5]);
  end

  assign n_o = n_r;

endmodule

// File: hdl/fractal_gradient_noise_2d_top.sv
// Top level of the fractal gradient noise block: configuration registers, shared
// frequency multiply, parallel octave lanes, octave sum and output saturation.
// Depends on fgn_pkg and fgn_octave.
// out_valid strobes after input capture, product, lane, sum and output registers.
// Throughput: one item per cycle; busy is never raised, every octave has its own lane.
// Reset (synchronous, rst_n low) clears the valid pipeline and loads register defaults.

module fractal_gradient_noise_2d_top #(
  parameter int MAX_OCTAVES      = fgn_pkg::MAX_OCTAVES_DEF,
  parameter int ANGLE_INDEX_BITS = fgn_pkg::ANGLE_INDEX_BITS_DEF,
  parameter int COORD_FRAC_BITS  = fgn_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  output logic               out_valid,
  output logic [15:0]        out_noise_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PROD_W = fgn_pkg::PROD_W;
  localparam int N_W    = fgn_pkg::N_W;
  localparam int SUM_W  = N_W + $clog2(MAX_OCTAVES) + 1;
  localparam int LAT    = fgn_pkg::LANE_LAT + 4;

  logic [31:0] seed_r;
  logic [23:0] freq_r;
  logic [3:0]  oct_r;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= fgn_pkg::SEED_RST;
      freq_r <= fgn_pkg::FREQ_RST;
      oct_r  <= fgn_pkg::OCT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        fgn_pkg::REG_SEED: seed_r <= pwdata;
        fgn_pkg::REG_FREQ: freq_r <= pwdata[23:0];
        fgn_pkg::REG_OCT:  oct_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fgn_pkg::REG_SEED: prdata = seed_r;
      fgn_pkg::REG_FREQ: prdata = {8'd0, freq_r};
      fgn_pkg::REG_OCT:  prdata = {28'd0, oct_r};
      default:           prdata = 32'd0;
    endcase
  end

  // Valid bits travel alongside the datapath.
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // Input capture and the one shared scale multiply; each lane applies its own shift.
  logic signed [31:0]       px_r;
  logic signed [31:0]       py_r;
  logic signed [PROD_W-1:0] prx_r;
  logic signed [PROD_W-1:0] pry_r;
  logic signed [24:0]       freq_s;
  assign freq_s = $signed({1'b0, freq_r});

  always_ff @(posedge clk) begin
    px_r  <= in_pos_x;
    py_r  <= in_pos_y;
    prx_r <= px_r * freq_s;
    pry_r <= py_r * freq_s;
  end

  logic signed [N_W-1:0] n_w [MAX_OCTAVES];
  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
    fgn_octave #(
      .OCT(o),
      .AIB(ANGLE_INDEX_BITS),
      .F  (COORD_FRAC_BITS)
    ) u_oct (
      .clk   (clk),
      .seed  (seed_r),
      .prod_x(prx_r),
      .prod_y(pry_r),
      .n_o   (n_w[o])
    );
  end

  // Weighted octave sum; lanes at or above the octave count add nothing.
  logic [4:0]              oct_ext;
  logic [4:0]              cnt;
  logic signed [SUM_W-1:0] sum_c;
  logic signed [SUM_W-1:0] sum_r;

  assign oct_ext = {1'b0, oct_r};
  assign cnt     = (oct_ext > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : oct_ext;

  always_comb begin
    sum_c = '0;
    for (int o = 0; o < MAX_OCTAVES; o++) begin
      if (5'(o) < cnt) begin
        sum_c = sum_c + SUM_W'(n_w[o] >>> o);
      end
    end
  end

  logic signed [SUM_W:0] res_c;
  logic [15:0]           out_nxt;
  assign res_c = (SUM_W+1)'(sum_r + SUM_W'(65536)) >>> 1;

  always_comb begin
    if (res_c < 0) begin
      out_nxt = 16'd0;
    end else if (res_c > (SUM_W+1)'(65535)) begin
      out_nxt = 16'hFFFF;
    end else begin
      out_nxt = res_c[15:0];
    end
  end

  always_ff @(posedge clk) begin
    sum_r           <= sum_c;
    out_noise_value <= out_nxt;
  end

endmodule

// File: test/fractal_gradient_noise_2d_top_test.sv
// Self-checking testbench for fractal_gradient_noise_2d_top: drives sample points,
// predicts each noise value in fixed point and compares it with the block's result.
// Depends on fgn_pkg for register indexes and on the RTL of the block.
`timescale 1ns / 100ps

module fractal_gradient_noise_2d_top_test;

  localparam int OCT_LIMIT  = 8;
  localparam int ANGLE_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int PIPE_LAT   = 13;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic out_valid;
  logic [15:0] out_noise_value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Configuration as the predictor sees it.
  logic [31:0] seed_cfg = 32'd0;
  logic [23:0] freq_cfg = 24'd65536;
  logic [3:0] oct_cfg = 4'd4;

  point_t point_q[$];
  logic [15:0] pending_noise[$];
  int sender_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  fractal_gradient_noise_2d_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_valid(out_valid), .out_noise_value(out_noise_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] corner_hash(input logic [31:0] v);
    logic [31:0] st;
    logic [31:0] w;
    st = v * 32'd747796405 + 32'd2891336453;
    w = ((st >> ((st >> 28) + 32'd4)) ^ st) * 32'd277803737;
    return (w >> 22) ^ w;
  endfunction

  // Quarter-wave sine in Q14 via a nested Taylor series in Q30.
  function automatic longint sine_quarter_q14(input int m);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] q;
    theta = ((64'(m) << (30 - (ANGLE_BITS - 2))) * 64'd1686629713) >> 30;
    t2 = (theta * theta) >> 30;
    acc = 64'd1 << 30;
    for (int n = 14; n >= 2; n -= 2) begin
      acc = (64'd1 << 30) - (((t2 * acc) >> 30) / 64'(n * (n + 1)));
    end
    s = (theta * acc) >> 30;
    q = (s + 64'd32768) >> 16;
    if (q > 64'd16384) begin
      q = 64'd16384;
    end
    return longint'(q);
  endfunction

  function automatic longint sine_full_q14(input int idx);
    int i;
    int quad;
    int r;
    longint v;
    i = idx & ((1 << ANGLE_BITS) - 1);
    quad = i >> (ANGLE_BITS - 2);
    r = i & ((1 << (ANGLE_BITS - 2)) - 1);
    v = sine_quarter_q14((quad & 1) ? (1 << (ANGLE_BITS - 2)) - r : r);
    return (quad & 2) ? -v : v;
  endfunction

  function automatic longint gradient_dot(input logic [31:0] cx, input logic [31:0] cy,
                                          input longint dx, input longint dy);
    logic [31:0] h;
    int idx;
    h = corner_hash(corner_hash(cx) + cy + seed_cfg);
    idx = int'(h >> (32 - ANGLE_BITS));
    return (dx * sine_full_q14(idx + (1 << (ANGLE_BITS - 2))) + dy * sine_full_q14(idx))
           >>> (FRAC_BITS - 2);
  endfunction

  function automatic longint quintic_fade(input longint t);
    longint t2;
    longint t3;
    t2 = (t * t) >> FRAC_BITS;
    t3 = (t2 * t) >> FRAC_BITS;
    return (t3 * (6 * t2 + 10 * (64'sd1 << FRAC_BITS) - 15 * t)) >> FRAC_BITS;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint f);
    return a + (((b - a) * f) >>> FRAC_BITS);
  endfunction

  function automatic logic [15:0] fbm_noise(input point_t p);
    longint px;
    longint py;
    longint one;
    longint sum;
    longint fx;
    longint fy;
    longint ux;
    longint uy;
    longint n;
    longint res;
    logic [63:0] freq;
    logic [63:0] sx;
    logic [63:0] sy;
    logic [31:0] x0;
    logic [31:0] y0;
    int count;
    px = longint'(p.x);
    py = longint'(p.y);
    one = 64'sd1 << FRAC_BITS;
    sum = 0;
    count = (oct_cfg > OCT_LIMIT) ? OCT_LIMIT : int'(oct_cfg);
    for (int o = 0; o < count; o++) begin
      freq = 64'(freq_cfg) << o;
      sx = px * freq;
      sy = py * freq;
      x0 = sx[FRAC_BITS +: 32];
      y0 = sy[FRAC_BITS +: 32];
      fx = longint'(sx[FRAC_BITS-1:0]);
      fy = longint'(sy[FRAC_BITS-1:0]);
      ux = quintic_fade(fx);
      uy = quintic_fade(fy);
      n = blend(blend(gradient_dot(x0, y0, fx, fy), gradient_dot(x0 + 1, y0, fx - one, fy), ux),
                blend(gradient_dot(x0, y0 + 1, fx, fy - one),
                      gradient_dot(x0 + 1, y0 + 1, fx - one, fy - one), ux), uy);
      sum += n >>> o;
    end
    res = (sum + 65536) >>> 1;
    if (res < 0) res = 0;
    if (res > 65535) res = 65535;
    return res[15:0];
  endfunction

  // Driver: an item is taken when start is high and busy low at the edge.
  always @(posedge clk) begin
    point_t p;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_noise.push_back(fbm_noise({in_pos_x, in_pos_y}));
      end
      if (!start || !busy) begin
        if (point_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          p = point_q.pop_front();
          in_pos_x <= p.x;
          in_pos_y <= p.y;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_valid) begin
      if (pending_noise.size() == 0) begin
        $error("noise_value: unexpected result %0d", out_noise_value);
        fail_count++;
      end else begin
        want = pending_noise.pop_front();
        if (out_noise_value !== want) begin
          $error("noise_value: expected %0d, actual %0d", want, out_noise_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      fgn_pkg::REG_SEED: seed_cfg = value;
      fgn_pkg::REG_FREQ: freq_cfg = value[23:0];
      fgn_pkg::REG_OCT:  oct_cfg = value[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] seed, input logic [31:0] freq,
                           input logic [31:0] oct);
    reg_write(fgn_pkg::REG_SEED, seed);
    reg_write(fgn_pkg::REG_FREQ, freq);
    reg_write(fgn_pkg::REG_OCT, oct);
  endtask

  // Waits until the block has drained so that registers may change.
  task automatic drain();
    while (point_q.size() > 0) @(posedge clk);
    @(posedge clk);
    while (start || pending_noise.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic push_point(input logic [31:0] x, input logic [31:0] y);
    point_q.push_back({x, y});
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: push_point($urandom, $urandom);
        1: push_point($urandom_range(200) - 100, $urandom_range(200) - 100);
        default: push_point($urandom_range(8191) - 4096, $urandom_range(8191) - 4096);
      endcase
    end
  endtask

  initial begin
    logic [31:0] freq;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points at the register defaults: extremes and signs.
    sender_idle_pct = 27;
    push_point(32'h0, 32'h0);
    push_point(32'h7fffffff, 32'h7fffffff);
    push_point(32'h80000000, 32'h80000000);
    push_point(32'h80000000, 32'h7fffffff);
    push_point(32'hffffffff, 32'hffffffff);
    push_point(32'h1, 32'hffffffff);
    push_point(32'h12345678, 32'hedcba987);
    drain();
    // Zero frequency gives one half everywhere; the octave count equals the limit.
    configure(32'hffffffff, 32'h0, 32'd8);
    push_point(32'h7fffffff, 32'h80000000);
    push_point(32'h55555555, 32'haaaaaaaa);
    drain();
    // Largest frequency makes the lattice coordinate wrap; an octave count above the limit saturates.
    configure(32'hffffffff, 32'hffffff, 32'd15);
    push_point(32'h7fffffff, 32'h80000000);
    push_point(32'hffffffff, 32'h1);
    push_point(32'h00010000, 32'hfffe0001);
    drain();
    configure(32'h0, 32'h8000, 32'd0);
    push_point(32'h3, 32'h5);
    push_point(32'h80000000, 32'h7fffffff);
    drain();
    configure(32'h9e3779b9, 32'h1000, 32'd8);
    for (int i = 0; i < 6; i++) push_point(i * 7 - 20, 100 - i * 33);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      sender_idle_pct = (ph < 4) ? 27 : (ph < 8) ? 66 : 0;
      case ($urandom_range(3))
        0: freq = $urandom_range(24'hffffff);
        1: freq = 32'h10000;
        default: freq = $urandom_range(32'h40000);
      endcase
      configure($urandom, freq, $urandom_range(15));
      push_random(90);
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
